@@ hdl/tcpcw_pkg.sv @@
// Shared types, constants and tables for the Reno congestion window block.
// Used by tcpcw_front, tcpcw_back and tcp_reno_congestion_window.
package tcpcw_pkg;

  localparam int MAX_WINDOW_DEF = 32;
  localparam int WIN_W          = 14;
  localparam int SEQ_W          = 16;
  localparam int ACK_W          = 17;
  localparam int THR_W          = 8;
  localparam int WHOLE_W        = 6;
  localparam int OP_W           = 2;
  localparam int KIND_W         = 2;
  localparam int PHASE_W        = 2;

  localparam logic [OP_W-1:0] OP_ACK     = 2'd0;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd1;
  localparam logic [OP_W-1:0] OP_START   = 2'd2;
  localparam logic [OP_W-1:0] OP_IGNORE  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEW   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RETX  = 2'd2;

  localparam logic [PHASE_W-1:0] PH_SLOW  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_AVOID = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RECOV = 2'd2;

  localparam logic [0:0] REG_TOTAL  = 1'b0;
  localparam logic [0:0] REG_THRESH = 1'b1;

  localparam logic [THR_W-1:0] THRESH_RESET = 8'd64;
  localparam logic [WIN_W-1:0] WIN_ONE      = 14'd256;

  typedef enum logic [1:0] {
    EV_ACK,
    EV_TIMEOUT,
    EV_START,
    EV_NONE
  } ev_t;

  typedef struct packed {
    ev_t              ev;
    logic [ACK_W-1:0] ack;
  } event_t;

  function automatic logic [8:0] recip_q(input logic [WHOLE_W-1:0] whole);
    logic [8:0] r;
    case (whole)
      6'd0, 6'd1: r = 9'd256;
      6'd2:  r = 9'd128;
      6'd3:  r = 9'd85;
      6'd4:  r = 9'd64;
      6'd5:  r = 9'd51;
      6'd6:  r = 9'd42;
      6'd7:  r = 9'd36;
      6'd8:  r = 9'd32;
      6'd9:  r = 9'd28;
      6'd10: r = 9'd25;
      6'd11: r = 9'd23;
      6'd12: r = 9'd21;
      6'd13: r = 9'd19;
      6'd14: r = 9'd18;
      6'd15: r = 9'd17;
      6'd16: r = 9'd16;
      6'd17: r = 9'd15;
      6'd18: r = 9'd14;
      6'd19: r = 9'd13;
      6'd20, 6'd21: r = 9'd12;
      6'd22, 6'd23: r = 9'd11;
      6'd24, 6'd25: r = 9'd10;
      6'd26, 6'd27, 6'd28: r = 9'd9;
      6'd29, 6'd30, 6'd31, 6'd32: r = 9'd8;
      6'd33, 6'd34, 6'd35, 6'd36: r = 9'd7;
      6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42: r = 9'd6;
      6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51: r = 9'd5;
      default: r = 9'd4;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/tcp_reno_congestion_window.sv @@
// Top level of the Reno congestion window controller: configuration registers,
// input queue (tcpcw_front) and event engine (tcpcw_back). Depends on tcpcw_pkg.
//
//   channel | handshake              | payload
//   in      | in_valid / in_stall    | op, ack_num
//   out     | out_valid / out_stall  | kind, seq, last, phase, window_whole, all_acked
//   cfg     | cfg_we                 | cfg_index, cfg_data
//
// An event is dispatched, then each packet covered by a cumulative ACK takes a
// window step and a send count, a send count follows where packets may go, and
// the results then transfer one per cycle while out_stall is low.
// The engine works one event at a time; a two-entry queue keeps taking input.
// Reset is synchronous and returns the engine to slow start with window 1.0.
// Output stalls hold the current result; input stalls only when the queue is full.
module tcp_reno_congestion_window #(
  parameter int MaxWindow = tcpcw_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcpcw_pkg::OP_W-1:0]    op,
  input  logic [tcpcw_pkg::ACK_W-1:0]   ack_num,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcpcw_pkg::KIND_W-1:0]  kind,
  output logic [tcpcw_pkg::SEQ_W-1:0]   seq,
  output logic                          last,
  output logic [tcpcw_pkg::PHASE_W-1:0] phase,
  output logic [tcpcw_pkg::WHOLE_W-1:0] window_whole,
  output logic                          all_acked,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [tcpcw_pkg::SEQ_W-1:0]   cfg_data
);
  import tcpcw_pkg::*;

  logic [SEQ_W-1:0] total_packets;
  logic [THR_W-1:0] initial_threshold;
  logic             q_valid;
  logic             q_pop;
  event_t           q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets     <= '0;
      initial_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL:  total_packets     <= cfg_data;
        REG_THRESH: initial_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  tcpcw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .ack_num  (ack_num),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  tcpcw_back #(.MaxWindow(MaxWindow)) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_item            (q_item),
    .total_packets     (total_packets),
    .initial_threshold (initial_threshold),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .seq               (seq),
    .last              (last),
    .phase             (phase),
    .window_whole      (window_whole),
    .all_acked         (all_acked)
  );

endmodule

@@ hdl/tcpcw_front.sv @@
// Input side: accepts events, decodes the op code and queues them.
// Depends on tcpcw_pkg.
module tcpcw_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tcpcw_pkg::OP_W-1:0] op,
  input  logic [tcpcw_pkg::ACK_W-1:0] ack_num,
  output logic                       q_valid,
  input  logic                       q_pop,
  output tcpcw_pkg::event_t          q_item
);
  import tcpcw_pkg::*;

  event_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  event_t     dec;

  always_comb begin
    case (op)
      OP_ACK:     dec.ev = EV_ACK;
      OP_TIMEOUT: dec.ev = EV_TIMEOUT;
      OP_START:   dec.ev = EV_START;
      default:    dec.ev = EV_NONE;
    endcase
    dec.ack = ack_num;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop && q_valid) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("full queue with unequal pointers");

endmodule

@@ hdl/tcpcw_back.sv @@
// Event engine: window, threshold and sequence state, send counting and result drain.
// Depends on tcpcw_pkg.
module tcpcw_back #(
  parameter int MaxWindow = tcpcw_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  tcpcw_pkg::event_t             q_item,
  input  logic [tcpcw_pkg::SEQ_W-1:0]   total_packets,
  input  logic [tcpcw_pkg::THR_W-1:0]   initial_threshold,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcpcw_pkg::KIND_W-1:0]  kind,
  output logic [tcpcw_pkg::SEQ_W-1:0]   seq,
  output logic                          last,
  output logic [tcpcw_pkg::PHASE_W-1:0] phase,
  output logic [tcpcw_pkg::WHOLE_W-1:0] window_whole,
  output logic                          all_acked
);
  import tcpcw_pkg::*;

  localparam int Cap  = MaxWindow + 1;
  localparam int CntW = $clog2(Cap + 1);
  localparam logic [WIN_W-1:0] WinCap = WIN_W'(MaxWindow * 256);
  localparam logic [CntW-1:0]  CapC   = CntW'(Cap);

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_SEND, S_EMIT} state_t;

  state_t              state;
  logic [PHASE_W-1:0]  phase_reg;
  logic [WIN_W-1:0]    window_q;
  logic [THR_W-1:0]    threshold_reg;
  logic [1:0]          dup_count;
  logic [SEQ_W-1:0]    base_seq;
  logic [SEQ_W-1:0]    next_seq;
  logic [SEQ_W-1:0]    top;
  logic                walk;
  logic                retx;
  logic [SEQ_W-1:0]    retx_seq;
  logic [SEQ_W-1:0]    send_start;
  logic [CntW-1:0]     res_n;
  logic [CntW-1:0]     idx;

  logic                busy;
  logic signed [17:0]  ack_s;
  logic signed [17:0]  base_s;
  logic [SEQ_W-1:0]    next_m1;
  logic [SEQ_W-1:0]    out_n;
  logic [23:0]         out_q;
  logic [WIN_W-1:0]    diff;
  logic [6:0]          n_win;
  logic [SEQ_W-1:0]    left;
  logic [CntW-1:0]     room;
  logic [SEQ_W-1:0]    n_send;
  logic [WIN_W:0]      win_inc;
  logic [WIN_W:0]      win_avoid;
  logic [15:0]         thr_q;
  logic [WIN_W-1:0]    thr_sat;
  logic [THR_W-1:0]    half_dn;
  logic [WIN_W-1:0]    tri_win;
  logic [WIN_W-1:0]    step_win;
  logic [CntW-1:0]     rel;

  function automatic logic [WIN_W-1:0] sat(input logic [WIN_W:0] w);
    return (w > {1'b0, WinCap}) ? WinCap : w[WIN_W-1:0];
  endfunction

  assign busy    = (base_seq != next_seq);
  assign ack_s   = {q_item.ack[ACK_W-1], q_item.ack};
  assign base_s  = $signed({2'b00, base_seq});
  assign next_m1 = next_seq - 16'd1;

  always_comb begin
    out_n = next_seq - base_seq;
    out_q = {out_n, 8'd0};
    diff  = window_q - out_q[WIN_W-1:0];
    n_win = 7'd0;
    if ({10'd0, window_q} > out_q) n_win = 7'((15'(diff) + 15'd255) >> 8);
    left  = (total_packets > next_seq) ? total_packets - next_seq : '0;
    room  = CapC - res_n;
    n_send = {9'd0, n_win};
    if (left < n_send) n_send = left;
    if ({{(SEQ_W-CntW){1'b0}}, room} < n_send) n_send = SEQ_W'(room);
  end

  always_comb begin
    win_inc   = {1'b0, window_q} + {1'b0, WIN_ONE};
    win_avoid = {1'b0, window_q} + (WIN_W+1)'(recip_q(window_q[WIN_W-1:8]));
    thr_q     = {threshold_reg, 8'd0};
    thr_sat   = (thr_q > {2'b00, WinCap}) ? WinCap : thr_q[WIN_W-1:0];
    half_dn   = THR_W'(window_q >> 9);
    if (half_dn == '0) half_dn = THR_W'(1);
    tri_win   = sat((WIN_W+1)'({half_dn, 8'd0}) + (WIN_W+1)'(3 * 256));
    case (phase_reg)
      PH_SLOW:  step_win = sat(win_inc);
      PH_AVOID: step_win = sat(win_avoid);
      default:  step_win = thr_sat;
    endcase
  end

  assign q_pop     = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign rel       = idx - CntW'(retx);

  always_comb begin
    if (res_n == '0) begin
      kind = KIND_NONE;
      seq  = '0;
    end else if (retx && idx == '0) begin
      kind = KIND_RETX;
      seq  = retx_seq;
    end else begin
      kind = KIND_NEW;
      seq  = send_start + SEQ_W'(rel);
    end
    last         = (res_n == '0) || (idx == res_n - CntW'(1));
    phase        = phase_reg;
    window_whole = window_q[WIN_W-1:8];
    all_acked    = (base_seq == next_seq) && (next_seq >= total_packets);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase_reg     <= PH_SLOW;
      window_q      <= WIN_ONE;
      threshold_reg <= THRESH_RESET;
      dup_count     <= 2'd0;
      base_seq      <= '0;
      next_seq      <= '0;
      walk          <= 1'b0;
      retx          <= 1'b0;
      res_n         <= '0;
      idx           <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            walk       <= 1'b0;
            retx       <= 1'b0;
            res_n      <= '0;
            idx        <= '0;
            send_start <= next_seq;
            retx_seq   <= base_seq;
            state      <= S_EMIT;
            case (q_item.ev)
              EV_START: begin
                phase_reg     <= PH_SLOW;
                window_q      <= WIN_ONE;
                threshold_reg <= initial_threshold;
                dup_count     <= 2'd0;
                base_seq      <= '0;
                next_seq      <= '0;
                send_start    <= '0;
                state         <= S_SEND;
              end
              EV_TIMEOUT: begin
                if (busy) begin
                  threshold_reg <= THR_W'(({1'b0, window_q} + 15'd511) >> 9);
                  window_q      <= WIN_ONE;
                  dup_count     <= 2'd0;
                  phase_reg     <= PH_SLOW;
                  retx          <= 1'b1;
                  res_n         <= CntW'(1);
                end
              end
              EV_ACK: begin
                if (busy) begin
                  if (ack_s == base_s - 18'sd1) begin
                    if (phase_reg == PH_RECOV) begin
                      if (dup_count != 2'd3) dup_count <= dup_count + 2'd1;
                      window_q <= sat(win_inc);
                      state    <= S_SEND;
                    end else if (dup_count == 2'd2) begin
                      threshold_reg <= half_dn;
                      window_q      <= tri_win;
                      dup_count     <= 2'd0;
                      phase_reg     <= PH_RECOV;
                      retx          <= 1'b1;
                      res_n         <= CntW'(1);
                      state         <= S_SEND;
                    end else begin
                      dup_count <= dup_count + 2'd1;
                    end
                  end else if (ack_s >= base_s) begin
                    top   <= (q_item.ack[SEQ_W-1:0] > next_m1) ? next_m1
                                                               : q_item.ack[SEQ_W-1:0];
                    walk  <= 1'b1;
                    state <= S_STEP;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_STEP: begin
          base_seq  <= base_seq + 16'd1;
          dup_count <= 2'd0;
          window_q  <= step_win;
          if (phase_reg == PH_SLOW) begin
            if ({2'b00, step_win} >= thr_q) phase_reg <= PH_AVOID;
          end else begin
            phase_reg <= PH_AVOID;
          end
          state <= S_SEND;
        end
        S_SEND: begin
          next_seq <= next_seq + n_send;
          res_n    <= res_n + CntW'(n_send);
          if (walk && base_seq <= top && base_seq != next_seq + n_send) begin
            state <= S_STEP;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + CntW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) window_q <= WinCap)
    else $error("window above its cap");
  assert property (@(posedge clk) disable iff (rst) res_n <= CapC)
    else $error("result count above room");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_stall) |=> (state == S_EMIT && $stable(idx)))
    else $error("drain advanced while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |=> (state == S_SEND))
    else $error("window step not followed by send count");

endmodule
